### sv/hdu_pkg.sv
// Package: constants, types and fixed-point helpers for the haversine distance unit.
`default_nettype none
package hdu_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int AW = 34;

   localparam logic signed [AW-1:0] GAIN_INV_Q30 = 34'sd652032874;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [AW-1:0] Q30_ONE = 34'sd1073741824;
   localparam logic signed [31:0] TURN_HU = 32'sd720000000;
   localparam logic signed [31:0] HALF_TURN_HU = 32'sd360000000;
   localparam logic signed [31:0] QUARTER_TURN_HU = 32'sd180000000;
   localparam logic [25:0] DIST_MAX = 26'd52707178;
   localparam logic [23:0] RADIUS_RESET = 24'd6371000;
   // rad_q29 = floor((mag * NUM + BIAS) / 2^12 / 46875), the divide by reciprocal
   localparam logic [29:0] HU_RAD_NUM = 30'd899535847;
   localparam logic [26:0] HU_RAD_BIAS = 27'd96000000;
   // ceil(2^61 / 46875)
   localparam logic [45:0] HU_RAD_RECIP = 46'd49191317529893;

   typedef logic signed [AW-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } cordic_type;

   typedef struct packed {
      logic [31:0] mag;
      logic        neg_ang;
      logic        neg_cos;
   } angle_type;

   function automatic word_type atan_q30(input int i);
      logic [31:0] t [32];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
            32'h00000001, 32'h00000000};
      return word_type'({2'b00, t[i & 31]});
   endfunction

   function automatic word_type qmul(input word_type a, input word_type b);
      logic signed [2*AW-1:0] p;
      p = a * b + 68'sd536870912;
      return word_type'(p >>> 30);
   endfunction

endpackage
`default_nettype wire

### sv/hdu_angle.sv
// Angle reduction of half-microdegree values to a folded Q30 radian angle.
`default_nettype none
module hdu_angle
   import hdu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic signed [31:0] ang,
   output word_type         z_ff,
   output logic             neg_cos_ff
);
   logic signed [31:0] r;
   angle_type a_in, a_ff;
   logic [57:0] num;
   logic [45:0] q_in, q_ff;
   logic [45:0] pp_hh_in, pp_hl_in, pp_lh_in, pp_ll_in;
   logic [45:0] pp_hh_ff, pp_hl_ff, pp_lh_ff, pp_ll_ff;
   logic [1:0] sign_q_ff, sign_p_ff;
   logic [91:0] prod;
   logic [29:0] rad;

   always_comb begin
      r = ang;
      a_in.neg_cos = 1'b0;
      if (r >= HALF_TURN_HU) r = r - TURN_HU;
      if (r < -HALF_TURN_HU) r = r + TURN_HU;
      if (r > QUARTER_TURN_HU) begin
         r = HALF_TURN_HU - r;
         a_in.neg_cos = 1'b1;
      end
      if (r < -QUARTER_TURN_HU) begin
         r = -HALF_TURN_HU - r;
         a_in.neg_cos = 1'b1;
      end
      a_in.neg_ang = r[31];
      a_in.mag = r[31] ? 32'(-r) : 32'(r);
   end

   always_ff @(posedge clock) begin
      if (enable) a_ff <= a_in;
   end

   always_comb begin
      num = 58'(a_ff.mag) * 58'(HU_RAD_NUM) + 58'(HU_RAD_BIAS);
      q_in = num[57:12];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
         sign_q_ff <= {a_ff.neg_ang, a_ff.neg_cos};
      end
   end

   always_comb begin
      pp_hh_in = 46'(q_ff[45:23]) * 46'(HU_RAD_RECIP[45:23]);
      pp_hl_in = 46'(q_ff[45:23]) * 46'(HU_RAD_RECIP[22:0]);
      pp_lh_in = 46'(q_ff[22:0]) * 46'(HU_RAD_RECIP[45:23]);
      pp_ll_in = 46'(q_ff[22:0]) * 46'(HU_RAD_RECIP[22:0]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_ll_ff <= pp_ll_in;
         sign_p_ff <= sign_q_ff;
      end
   end

   always_comb begin
      prod = (92'(pp_hh_ff) << 46) + (92'(pp_hl_ff) << 23) + (92'(pp_lh_ff) << 23)
           + 92'(pp_ll_ff);
      rad = prod[90:61];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff <= sign_p_ff[1] ? -word_type'({rad, 1'b0}) : word_type'({rad, 1'b0});
         neg_cos_ff <= sign_p_ff[0];
      end
   end
endmodule
`default_nettype wire

### sv/hdu_cordic.sv
// One pipelined CORDIC iteration, rotation or vectoring mode.
`default_nettype none
module hdu_cordic
   import hdu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       enable,
   input  wire logic       vectoring,
   input  wire logic [4:0] step,
   input  cordic_type      d_in,
   output cordic_type      d_ff
);
   cordic_type n_in;
   logic up;
   word_type dx, dy, t;
   always_comb begin
      dx = d_in.y >>> step;
      dy = d_in.x >>> step;
      t = atan_q30(int'(step));
      up = vectoring ? d_in.y[AW-1] : !d_in.z[AW-1];
      n_in.x = up ? d_in.x - dx : d_in.x + dx;
      n_in.y = up ? d_in.y + dy : d_in.y - dy;
      if (vectoring) n_in.z = up ? d_in.z - t : d_in.z + t;
      else n_in.z = up ? d_in.z - t : d_in.z + t;
   end
   always_ff @(posedge clock) begin
      if (enable) d_ff <= n_in;
   end
endmodule
`default_nettype wire

### sv/hdu_sqrt.sv
// Pipelined bit-by-bit square root of a Q30 value, one result bit per stage.
`default_nettype none
module hdu_sqrt
   import hdu_pkg::*;
(
   input  wire logic clock,
   input  wire logic enable,
   input  word_type  v,
   output word_type  root
);
   logic [61:0] rem_ff [32];
   logic [61:0] res_ff [32];
   logic [61:0] rem_in [31];
   logic [61:0] res_in [31];
   always_comb begin
      for (int k = 0; k < 31; k++) begin
         logic [61:0] bitv;
         bitv = 62'd1 << (2 * (30 - k));
         if (rem_ff[k] >= res_ff[k] + bitv) begin
            rem_in[k] = rem_ff[k] - (res_ff[k] + bitv);
            res_in[k] = (res_ff[k] >> 1) + bitv;
         end else begin
            rem_in[k] = rem_ff[k];
            res_in[k] = res_ff[k] >> 1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {v[31:0], 30'd0};
         res_ff[0] <= '0;
         for (int k = 0; k < 31; k++) begin
            rem_ff[k+1] <= rem_in[k];
            res_ff[k+1] <= res_in[k];
         end
      end
   end
   assign root = word_type'(res_ff[31][33:0]);
endmodule
`default_nettype wire

### sv/haversine_distance_unit.sv
// Top level: pipelined haversine great-circle distance unit.
// Accepts one coordinate pair per cycle while req_stall is low and returns one distance per
// pair, in order, through the pipeline stages: angle reduction (4), sine/cosine CORDIC
// (24 stages), haversine products (3), square roots (32), arctangent CORDIC (24) and scaling
// (2). The whole pipeline advances when the output register is empty or being taken; rsp_stall
// holds every stage. The radius register may be written only while the pipeline is empty.
`default_nettype none
module haversine_distance_unit
   import hdu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [27:0] req_lat_a,
   input  wire logic [28:0] req_lon_a,
   input  wire logic [27:0] req_lat_b,
   input  wire logic [28:0] req_lon_b,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [25:0]      rsp_distance_m,
   input  wire logic        csr_write,
   input  wire logic [23:0] csr_data
);
   localparam int N = CORDIC_STEPS;
   localparam int LAT = 4 + N + 3 + 32 + N + 2;

   logic enable;
   logic [23:0] radius_ff;
   logic [LAT-1:0] valid_ff;
   logic signed [31:0] ang [4];
   word_type zr [4];
   logic ncos [4];
   logic ncos_ff [4][N];
   cordic_type cs [4][N+1];

   assign enable = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) radius_ff <= RADIUS_RESET;
      else if (csr_write) radius_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= {valid_ff[LAT-2:0], req_valid};
   end
   assign rsp_valid = valid_ff[LAT-1];

   always_comb begin
      ang[0] = 32'($signed(req_lat_b)) - 32'($signed(req_lat_a));
      ang[1] = 32'($signed(req_lon_b)) - 32'($signed(req_lon_a));
      ang[2] = 32'($signed(req_lat_a)) <<< 1;
      ang[3] = 32'($signed(req_lat_b)) <<< 1;
   end

   for (genvar g = 0; g < 4; g++) begin : g_trig
      hdu_angle u_angle (.clock, .enable, .ang(ang[g]), .z_ff(zr[g]), .neg_cos_ff(ncos[g]));
      assign cs[g][0] = '{x: GAIN_INV_Q30, y: '0, z: zr[g]};
      for (genvar i = 0; i < N; i++) begin : g_step
         hdu_cordic u_step (.clock, .enable, .vectoring(1'b0), .step(5'(i)),
                            .d_in(cs[g][i]), .d_ff(cs[g][i+1]));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) begin
            ncos_ff[k][0] <= ncos[k];
            for (int i = 1; i < N; i++) ncos_ff[k][i] <= ncos_ff[k][i-1];
         end
      end
   end

   word_type c1, c2, p_dlat_ff, p_dlon_ff, p_cc_ff, p_b_ff, a_ff, a_in, a_sum, sa, sb;
   assign c1 = ncos_ff[2][N-1] ? -cs[2][N].x : cs[2][N].x;
   assign c2 = ncos_ff[3][N-1] ? -cs[3][N].x : cs[3][N].x;

   always_ff @(posedge clock) begin
      if (enable) begin
         p_dlat_ff <= qmul(cs[0][N].y, cs[0][N].y);
         p_dlon_ff <= qmul(cs[1][N].y, cs[1][N].y);
         p_cc_ff <= qmul(c1, c2);
         p_b_ff <= p_dlat_ff;
         a_ff <= a_in;
      end
   end
   logic signed [AW-1:0] p_ab_ff;
   always_ff @(posedge clock) begin
      if (enable) p_ab_ff <= qmul(p_cc_ff, p_dlon_ff);
   end
   always_comb begin
      a_sum = p_b_ff + p_ab_ff;
      if (a_sum < 0) a_in = '0;
      else if (a_sum > Q30_ONE) a_in = Q30_ONE;
      else a_in = a_sum;
   end

   hdu_sqrt u_sqrt_a (.clock, .enable, .v(a_ff), .root(sa));
   hdu_sqrt u_sqrt_b (.clock, .enable, .v(Q30_ONE - a_ff), .root(sb));

   cordic_type vs [N+1];
   assign vs[0] = '{x: sb, y: sa, z: '0};
   for (genvar i = 0; i < N; i++) begin : g_vec
      hdu_cordic u_step (.clock, .enable, .vectoring(1'b1), .step(5'(i)),
                         .d_in(vs[i]), .d_ff(vs[i+1]));
   end

   word_type z_in, z_ff;
   logic [59:0] d_prod;
   logic [29:0] d_full;
   always_comb begin
      if (vs[N].z < 0) z_in = '0;
      else if (vs[N].z > HALF_PI_Q30) z_in = HALF_PI_Q30;
      else z_in = vs[N].z;
   end
   always_ff @(posedge clock) begin
      if (enable) z_ff <= z_in;
   end
   always_comb begin
      d_prod = 60'({radius_ff, 1'b0}) * 60'(z_ff[30:0]) + 60'd536870912;
      d_full = 30'(d_prod >> 30);
   end
   always_ff @(posedge clock) begin
      if (enable) rsp_distance_m <= (d_full > 30'(DIST_MAX)) ? DIST_MAX : d_full[25:0];
   end
endmodule
`default_nettype wire
